### hdl/mqpd_pkg.sv
// Shared types and codes for the multi-class queue bank.
package mqpd_pkg;

    localparam int CLASS_W = 5;
    localparam int MODE_W  = 2;
    localparam int CODE_W  = 3;
    localparam int FILL_W  = 4;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;

    // Result codes
    localparam logic [CODE_W-1:0] RC_ADDED  = 3'd0;
    localparam logic [CODE_W-1:0] RC_FULL   = 3'd1;
    localparam logic [CODE_W-1:0] RC_POPPED = 3'd2;
    localparam logic [CODE_W-1:0] RC_EMPTY  = 3'd3;
    localparam logic [CODE_W-1:0] RC_DUMP   = 3'd4;

    // Decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_ADD,
        OP_POP,
        OP_DUMP,
        OP_REJECT,
        OP_MISS
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CLASS_W-1:0] cls;
        logic               urgent;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

### hdl/mqpd_if.sv
// Request and response channel interfaces.
interface mqpd_req_if #(parameter int ID_WIDTH = 16);
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [4:0]          class_index;
    logic [ID_WIDTH-1:0] entry_id;
    logic                urgent;

    modport source (output valid, output mode, output class_index, output entry_id,
                    output urgent, input ready);
    modport sink   (input valid, input mode, input class_index, input entry_id,
                    input urgent, output ready);
endinterface

interface mqpd_rsp_if #(parameter int ID_WIDTH = 16);
    logic                valid;
    logic                ready;
    logic [2:0]          result_code;
    logic [4:0]          queue_index;
    logic [ID_WIDTH-1:0] out_entry_id;
    logic                out_urgent;
    logic [3:0]          fill_count;
    logic                last;

    modport source (output valid, output result_code, output queue_index,
                    output out_entry_id, output out_urgent, output fill_count,
                    output last, input ready);
    modport sink   (input valid, input result_code, input queue_index,
                    input out_entry_id, input out_urgent, input fill_count,
                    input last, output ready);
endinterface

### hdl/mqpd_front.sv
// Front end: accepts requests and decodes them into commands.
module mqpd_front #(
    parameter int NUM_QUEUES = 32,
    parameter int ID_WIDTH   = 16
) (
    mqpd_req_if.sink            req,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output mqpd_pkg::cmd_t      cmd,
    output logic [ID_WIDTH-1:0] cmd_id
);
    import mqpd_pkg::*;

    logic in_range;

    assign req.ready = cmd_ready;
    assign in_range  = (int'(req.class_index) < NUM_QUEUES);

    // Mode 3 is taken and dropped
    assign cmd_valid  = req.valid && (req.mode != MODE_NOP);
    assign cmd_id     = req.entry_id;

    always_comb
    begin
        cmd.cls    = req.class_index;
        cmd.urgent = req.urgent;
        case (req.mode)
            MODE_ADD:  cmd.op = in_range ? OP_ADD  : OP_REJECT;
            MODE_POP:  cmd.op = in_range ? OP_POP  : OP_MISS;
            MODE_DUMP: cmd.op = in_range ? OP_DUMP : OP_MISS;
            default:   cmd.op = OP_MISS;
        endcase
    end

endmodule

### hdl/mqpd_cmd_fifo.sv
// Two-entry command queue between front and back.
module mqpd_cmd_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_data;
    end

endmodule

### hdl/mqpd_back.sv
// Back end: per-class circular queues in one memory, plus the result register.
module mqpd_back #(
    parameter int NUM_QUEUES  = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  mqpd_pkg::cmd_t      cmd,
    input  logic [ID_WIDTH-1:0] cmd_id,
    mqpd_rsp_if.source          rsp
);
    import mqpd_pkg::*;

    localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SW1   = SW + 1;
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);

    // Memory word: {urgent, id}
    logic [ID_WIDTH:0] mem [SLOTS];
    logic [ID_WIDTH:0] rd_data_reg;
    logic              re, we;
    logic [AW-1:0]     ra, wa;
    logic [ID_WIDTH:0] wd;

    logic [SW-1:0] head_reg [NUM_QUEUES];
    logic [FW-1:0] fill_reg [NUM_QUEUES];

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [QW-1:0]       qi_reg;
    logic [SW-1:0]       head_sel_reg;
    logic [FW-1:0]       len_reg;
    logic [SW-1:0]       idx_reg, idx_next;

    logic [QW+4:0]       qi_ext;
    logic [QW-1:0]       qi_in;
    logic                upd;
    logic [SW-1:0]       head_new;
    logic [FW-1:0]       fill_new;

    logic                out_valid_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [CLASS_W-1:0]  qidx_reg;
    logic [ID_WIDTH-1:0] oid_reg;
    logic                ourg_reg;
    logic [FW-1:0]       ofill_reg;
    logic                last_reg;
    logic [FW+3:0]       ofill_ext;

    logic                out_free, emit;
    logic [CODE_W-1:0]   e_code;
    logic [ID_WIDTH-1:0] e_id;
    logic                e_urg;
    logic [FW-1:0]       e_fill;
    logic                e_last;
    logic                dump_more;

    function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b);
        logic [SW1-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SW1'(QUEUE_DEPTH))
            s = s - SW1'(QUEUE_DEPTH);
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] a);
        return (a == '0) ? SW'(QUEUE_DEPTH - 1) : a - 1'b1;
    endfunction

    function automatic logic [AW-1:0] addr(input logic [QW-1:0] q, input logic [SW-1:0] s);
        return AW'(q) * AW'(QUEUE_DEPTH) + AW'(s);
    endfunction

    assign qi_ext    = {{QW{1'b0}}, cmd.cls};
    assign qi_in     = qi_ext[QW-1:0];
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        re         = 1'b0;
        ra         = '0;
        we         = 1'b0;
        wa         = '0;
        wd         = {cmd_reg.urgent, id_reg};
        upd        = 1'b0;
        head_new   = head_sel_reg;
        fill_new   = len_reg;
        emit       = 1'b0;
        e_code     = RC_EMPTY;
        e_id       = '0;
        e_urg      = 1'b0;
        e_fill     = '0;
        e_last     = 1'b1;
        dump_more  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                    // Prefetch the head slot for pop and dump
                    re = (cmd.op == OP_POP) || (cmd.op == OP_DUMP);
                    ra = addr(qi_in, head_reg[qi_in]);
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    case (cmd_reg.op)
                        OP_REJECT:
                            e_code = RC_FULL;
                        OP_ADD:
                        begin
                            if (len_reg == FW'(QUEUE_DEPTH))
                            begin
                                e_code = RC_FULL;
                                e_fill = len_reg;
                            end
                            else
                            begin
                                we       = 1'b1;
                                head_new = cmd_reg.urgent ? slot_dec(head_sel_reg)
                                                          : head_sel_reg;
                                wa       = addr(qi_reg, cmd_reg.urgent ? head_new :
                                                slot_add(head_sel_reg, len_reg[SW-1:0]));
                                upd      = 1'b1;
                                fill_new = len_reg + 1'b1;
                                e_code   = RC_ADDED;
                                e_fill   = fill_new;
                            end
                        end
                        OP_POP:
                        begin
                            if (len_reg != '0)
                            begin
                                upd      = 1'b1;
                                head_new = slot_add(head_sel_reg, SW'(1));
                                fill_new = len_reg - 1'b1;
                                e_code   = RC_POPPED;
                                e_id     = rd_data_reg[ID_WIDTH-1:0];
                                e_urg    = rd_data_reg[ID_WIDTH];
                                e_fill   = fill_new;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (len_reg != '0)
                            begin
                                e_code = RC_DUMP;
                                e_id   = rd_data_reg[ID_WIDTH-1:0];
                                e_urg  = rd_data_reg[ID_WIDTH];
                                e_fill = len_reg;
                                e_last = (FW'(idx_reg) + 1'b1 == len_reg);
                                if (!e_last)
                                begin
                                    dump_more = 1'b1;
                                    idx_next  = idx_reg + 1'b1;
                                    re        = 1'b1;
                                    ra        = addr(qi_reg, slot_add(head_sel_reg, idx_next));
                                end
                            end
                        end
                        default:
                            e_code = RC_EMPTY;
                    endcase
                    if (!dump_more)
                    begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (upd)
            begin
                head_reg[qi_reg] <= head_new;
                fill_reg[qi_reg] <= fill_new;
            end
        end
    end

    // Command latch; bad classes never use the table lookups
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
            id_reg  <= cmd_id;
            qi_reg  <= qi_in;
            if ((cmd.op == OP_REJECT) || (cmd.op == OP_MISS))
            begin
                head_sel_reg <= '0;
                len_reg      <= '0;
            end
            else
            begin
                head_sel_reg <= head_reg[qi_in];
                len_reg      <= fill_reg[qi_in];
            end
        end
        if (emit)
        begin
            code_reg  <= e_code;
            qidx_reg  <= cmd_reg.cls;
            oid_reg   <= e_id;
            ourg_reg  <= e_urg;
            ofill_reg <= e_fill;
            last_reg  <= e_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rd_data_reg <= mem[ra];
    end

    assign ofill_ext        = {4'b0, ofill_reg};
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_code  = code_reg;
    assign rsp.queue_index  = qidx_reg;
    assign rsp.out_entry_id = oid_reg;
    assign rsp.out_urgent   = ourg_reg;
    assign rsp.fill_count   = ofill_ext[3:0];
    assign rsp.last         = last_reg;

endmodule

### hdl/multi_queue_priority_deque.sv
// Top level of the multi-class bounded queue bank with head insertion.
//
//  channel | direction | transaction
//  --------+-----------+-------------------------------------------------------
//  req     | in        | mode, class_index, entry_id, urgent
//  rsp     | out       | result_code, queue_index, out_entry_id, out_urgent,
//          |           | fill_count, last
//
// Add, pop and rejected requests pass the back-end state ST_IDLE, which fetches the
// class's head pointer and fill count and prefetches the head slot, then ST_EXEC,
// which updates the queue and loads the result register. A dump stays in ST_EXEC
// for one result per entry, bound by the single registered read port of the entry
// memory (one result for an empty class). Mode 3 transactions are taken by the
// front and dropped. Reset clears every fill count and head pointer at once; there
// is no clearing pass. The front keeps accepting into a two-entry command queue
// while the back waits on a stalled rsp channel; results are never dropped or reordered.
module multi_queue_priority_deque #(
    parameter int NUM_QUEUES  = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mqpd_req_if.sink   req,
    mqpd_rsp_if.source rsp
);
    import mqpd_pkg::*;

    localparam int CW = $bits(cmd_t) + ID_WIDTH;

    // Front to queue
    logic                f_valid, f_ready;
    cmd_t                f_cmd;
    logic [ID_WIDTH-1:0] f_id;

    // Queue to back
    logic                b_valid, b_ready;
    logic [CW-1:0]       b_data;
    cmd_t                b_cmd;
    logic [ID_WIDTH-1:0] b_id;

    mqpd_front #(
        .NUM_QUEUES (NUM_QUEUES),
        .ID_WIDTH   (ID_WIDTH)
    ) u_front (
        .req       (req),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd),
        .cmd_id    (f_id)
    );

    mqpd_cmd_fifo #(
        .W (CW)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_cmd, f_id}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    assign b_cmd = cmd_t'(b_data[CW-1:ID_WIDTH]);
    assign b_id  = b_data[ID_WIDTH-1:0];

    mqpd_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd       (b_cmd),
        .cmd_id    (b_id),
        .rsp       (rsp)
    );

endmodule

### hdl/mqpd_checker.sv
// Port-level checks on the response channel, bound to the top level.
module mqpd_checker #(
    parameter int ID_WIDTH = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [2:0]          result_code,
    input logic [ID_WIDTH-1:0] out_entry_id,
    input logic                out_urgent,
    input logic [3:0]          fill_count,
    input logic                last
);
    import mqpd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_code)
            && $stable(out_entry_id) && $stable(last))
        else $error("response changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> result_code <= RC_DUMP)
        else $error("undefined result code");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_code == RC_ADDED || result_code == RC_FULL
            || result_code == RC_POPPED || result_code == RC_EMPTY) |-> last)
        else $error("single-result transaction not marked last");

    a_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_code == RC_ADDED || result_code == RC_FULL
            || result_code == RC_EMPTY) |-> out_entry_id == '0 && !out_urgent)
        else $error("entry fields set on a status result");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && result_code == RC_EMPTY |-> fill_count == 4'd0)
        else $error("empty result with nonzero fill");

endmodule

bind multi_queue_priority_deque mqpd_checker #(.ID_WIDTH(ID_WIDTH)) u_mqpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_code  (rsp.result_code),
    .out_entry_id (rsp.out_entry_id),
    .out_urgent   (rsp.out_urgent),
    .fill_count   (rsp.fill_count),
    .last         (rsp.last)
);
